// ===== sv/fua_pkg.sv =====
// shared types and constants of the h.264 rtp fu-a packetizer
// used by fua_front, fua_queue, fua_back and the top level
package fua_pkg;

  localparam int unsigned MaxFragments = 64;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);
  // width of chunk * MaxFragments
  localparam int unsigned LimitW       = 16 + $clog2(MaxFragments + 1);

  localparam logic [7:0] TypeMask   = 8'h1F;
  localparam logic [7:0] FnriMask   = 8'hE0;
  localparam logic [7:0] FuaType    = 8'd28;
  localparam logic [7:0] StartBit   = 8'h80;
  localparam logic [7:0] EndBit     = 8'h40;
  localparam logic [4:0] SpsType    = 5'd7;
  localparam logic [4:0] PpsType    = 5'd8;

  localparam logic [15:0] MaxPayloadReset  = 16'd1400;
  localparam logic [31:0] TsIncrementReset = 32'd3600;

  // configuration register indexes
  localparam logic [3:0] RegMaxPayload  = 4'd0;
  localparam logic [3:0] RegTsIncrement = 4'd1;

  // how a unit is carried
  localparam logic [1:0] KindSingle = 2'd0;
  localparam logic [1:0] KindFrag   = 2'd1;
  localparam logic [1:0] KindBig    = 2'd2;

  typedef struct packed {
    logic [7:0]  hdr;
    logic [1:0]  kind;
    logic [15:0] size;   // unit size in single mode, bytes after the header otherwise
  } fua_entry_t;

  typedef struct packed {
    logic       valid;
    fua_entry_t entry;
  } fua_push_t;

endpackage

// ===== sv/h264_rtp_fua_packetizer.sv =====
// top level of the h.264 rtp packetizer (single nal unit and fu-a modes)
// depends on fua_pkg, fua_front, fua_queue, fua_back
//
// usage:
// - input channel: one nal unit descriptor (header byte, total size) per item,
//   taken at a clock edge with in_valid_i high and in_stall_o low
// - output channel: packet descriptors, taken with out_valid_o high and
//   out_stall_i low; last_o marks the final descriptor of a unit
// - config channel: cfg_ready_o is always high; index 0 is max_payload,
//   index 1 is ts_increment; write only while the block is idle
// - a unit gives one descriptor (single, or too_large) or n fu-a fragments
//   (n up to 64); the back sequencer emits one descriptor per cycle while
//   out_stall_i is low, one descriptor for each fragment of a unit
// - path: an item is written into the queue at its accepting edge, and the
//   back loads its first descriptor from the queue head into the output
//   register; the two-entry queue lets the front keep accepting while
//   the back is busy fragmenting
// - stall: the output register holds its descriptor; the back pauses and
//   the queue fills, after which in_stall_o rises
// - reset: sequence, timestamp and queue clear; registers go to 1400 / 3600
module h264_rtp_fua_packetizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // nal unit input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  nal_header_i,
  input  logic [15:0] nal_size_i,
  // packet descriptor output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  hdr_byte0_o,
  output logic [7:0]  fu_header_o,
  output logic        fragmented_o,
  output logic [15:0] byte_offset_o,
  output logic [15:0] byte_count_o,
  output logic [15:0] seq_number_o,
  output logic [31:0] rtp_time_o,
  output logic        too_large_o,
  output logic        last_o
);
  import fua_pkg::*;

  logic [15:0] max_payload_q;
  logic [31:0] ts_increment_q;
  logic [15:0] chunk;
  fua_push_t   push;
  fua_entry_t  head;
  logic        q_full, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q  <= MaxPayloadReset;
      ts_increment_q <= TsIncrementReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegMaxPayload:  max_payload_q  <= cfg_data_i[15:0];
        RegTsIncrement: ts_increment_q <= cfg_data_i;
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  // a zero payload limit behaves as one byte
  assign chunk = (max_payload_q == '0) ? 16'd1 : max_payload_q;

  fua_front u_front (
    .in_valid_i   (in_valid_i),
    .nal_header_i (nal_header_i),
    .nal_size_i   (nal_size_i),
    .chunk_i      (chunk),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push)
  );

  fua_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  fua_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .chunk_i        (chunk),
    .ts_increment_i (ts_increment_q),
    .q_valid_i      (q_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .hdr_byte0_o    (hdr_byte0_o),
    .fu_header_o    (fu_header_o),
    .fragmented_o   (fragmented_o),
    .byte_offset_o  (byte_offset_o),
    .byte_count_o   (byte_count_o),
    .seq_number_o   (seq_number_o),
    .rtp_time_o     (rtp_time_o),
    .too_large_o    (too_large_o),
    .last_o         (last_o)
  );

endmodule

// ===== sv/fua_front.sv =====
// front part: takes nal unit descriptors and classifies them
// depends on fua_pkg
module fua_front (
  input  logic                 in_valid_i,
  input  logic [7:0]           nal_header_i,
  input  logic [15:0]          nal_size_i,
  input  logic [15:0]          chunk_i,
  input  logic                 q_full_i,
  output logic                 in_stall_o,
  output fua_pkg::fua_push_t   push_o
);
  import fua_pkg::*;

  logic [15:0]       payload;
  logic [LimitW-1:0] limit;
  logic              fits;
  logic              big;

  always_comb begin
    payload = nal_size_i - 16'd1;
    limit   = LimitW'(chunk_i) * LimitW'(MaxFragments);
    fits    = nal_size_i <= chunk_i;
    big     = LimitW'(payload) > limit;

    push_o.valid     = in_valid_i && !q_full_i;
    push_o.entry.hdr = nal_header_i;
    if (fits) begin
      push_o.entry.kind = KindSingle;
      push_o.entry.size = nal_size_i;
    end else if (big) begin
      push_o.entry.kind = KindBig;
      push_o.entry.size = payload;
    end else begin
      push_o.entry.kind = KindFrag;
      push_o.entry.size = payload;
    end
  end

  assign in_stall_o = q_full_i;

endmodule

// ===== sv/fua_queue.sv =====
// short fifo of classified units between front and back
// depends on fua_pkg
module fua_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fua_pkg::fua_push_t   push_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output fua_pkg::fua_entry_t  head_o
);
  import fua_pkg::*;

  fua_entry_t             entries_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   do_push, do_pop;

  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    if (p == QueuePtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + QueuePtrW'(1);
  endfunction

  assign full_o  = count_q == QueueCntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i.valid && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ===== sv/fua_back.sv =====
// back part: turns queued units into packet descriptors, one per cycle while out_stall_i is low
// depends on fua_pkg; holds sequence number and timestamp state
module fua_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          chunk_i,
  input  logic [31:0]          ts_increment_i,
  input  logic                 q_valid_i,
  input  fua_pkg::fua_entry_t  head_i,
  output logic                 pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [7:0]           hdr_byte0_o,
  output logic [7:0]           fu_header_o,
  output logic                 fragmented_o,
  output logic [15:0]          byte_offset_o,
  output logic [15:0]          byte_count_o,
  output logic [15:0]          seq_number_o,
  output logic [31:0]          rtp_time_o,
  output logic                 too_large_o,
  output logic                 last_o
);
  import fua_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StFrag = 1'b1;

  logic        state_q, state_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [15:0] off_q, off_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  hdr_q;
  logic        out_valid_q, out_valid_d;

  logic [7:0]  hdr_byte0_q, fu_header_q;
  logic        fragmented_q, too_large_q, last_q;
  logic [15:0] byte_offset_q, byte_count_q, seq_number_q;
  logic [31:0] rtp_time_q;

  logic        can_load, start, step, load;
  logic [7:0]  cur_hdr;
  logic [15:0] src_left, src_off, cnt;
  logic        frag_fin, first;
  logic [4:0]  nal_type;
  logic        param_set;

  always_comb begin
    can_load  = !out_valid_q || !out_stall_i;
    start     = (state_q == StIdle) && q_valid_i && can_load;
    step      = (state_q == StFrag) && can_load;
    first     = state_q == StIdle;
    cur_hdr   = first ? head_i.hdr : hdr_q;
    nal_type  = cur_hdr[4:0];
    param_set = (nal_type == SpsType) || (nal_type == PpsType);
    src_left  = first ? head_i.size : left_q;
    src_off   = first ? 16'd1 : off_q;
    frag_fin  = src_left <= chunk_i;
    cnt       = frag_fin ? src_left : chunk_i;
    load      = 1'b0;

    state_d     = state_q;
    seq_d       = seq_q;
    ts_d        = ts_q;
    off_d       = off_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (start) begin
      load        = 1'b1;
      out_valid_d = 1'b1;
      case (head_i.kind)
        KindSingle: begin
          seq_d  = seq_q + 16'd1;
          ts_d   = param_set ? ts_q : ts_q + ts_increment_i;
          off_d  = head_i.size;
          left_d = '0;
        end
        KindFrag: begin
          seq_d   = seq_q + 16'd1;
          off_d   = src_off + cnt;
          left_d  = src_left - cnt;
          ts_d    = frag_fin ? ts_q + ts_increment_i : ts_q;
          state_d = frag_fin ? StIdle : StFrag;
        end
        default: begin
          // oversized unit: popped and given a too_large descriptor; sequence, timestamp and state unchanged
        end
      endcase
    end else if (step) begin
      load        = 1'b1;
      out_valid_d = 1'b1;
      seq_d       = seq_q + 16'd1;
      off_d       = src_off + cnt;
      left_d      = src_left - cnt;
      ts_d        = frag_fin ? ts_q + ts_increment_i : ts_q;
      state_d     = frag_fin ? StIdle : StFrag;
    end
  end

  assign pop_o = start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seq_q       <= '0;
      ts_q        <= '0;
      off_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seq_q       <= seq_d;
      ts_q        <= ts_d;
      off_q       <= off_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register, only loaded when free or being taken
  always_ff @(posedge clk_i) begin
    if (start) begin
      hdr_q <= head_i.hdr;
    end
    if (load) begin
      seq_number_q <= seq_q;
      rtp_time_q   <= ts_q;
      if (first && head_i.kind == KindSingle) begin
        hdr_byte0_q   <= cur_hdr;
        fu_header_q   <= '0;
        fragmented_q  <= 1'b0;
        byte_offset_q <= '0;
        byte_count_q  <= head_i.size;
        too_large_q   <= 1'b0;
        last_q        <= 1'b1;
      end else if (first && head_i.kind == KindBig) begin
        hdr_byte0_q   <= cur_hdr;
        fu_header_q   <= '0;
        fragmented_q  <= 1'b0;
        byte_offset_q <= '0;
        byte_count_q  <= '0;
        too_large_q   <= 1'b1;
        last_q        <= 1'b1;
      end else begin
        hdr_byte0_q   <= (cur_hdr & FnriMask) | FuaType;
        fu_header_q   <= (cur_hdr & TypeMask) | (first ? StartBit : 8'h00)
                         | (frag_fin ? EndBit : 8'h00);
        fragmented_q  <= 1'b1;
        byte_offset_q <= src_off;
        byte_count_q  <= cnt;
        too_large_q   <= 1'b0;
        last_q        <= frag_fin;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hdr_byte0_o   = hdr_byte0_q;
  assign fu_header_o   = fu_header_q;
  assign fragmented_o  = fragmented_q;
  assign byte_offset_o = byte_offset_q;
  assign byte_count_o  = byte_count_q;
  assign seq_number_o  = seq_number_q;
  assign rtp_time_o    = rtp_time_q;
  assign too_large_o   = too_large_q;
  assign last_o        = last_q;

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == StIdle)
    else $error("queue popped while fragmenting");

  a_frag_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFrag |-> left_q != '0)
    else $error("fragmenting with no bytes left");

  a_big_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && too_large_q |-> last_q && !fragmented_q)
    else $error("oversized unit result malformed");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> seq_q == $past(seq_q) + 16'd1)
    else $error("sequence did not advance on fragment");

endmodule
